// File: rtl/core/pllm_pkg.sv
// ----------------------------------------------------------------------------
// pllm_pkg
// Shared types and codes for the pooled linked list manager: datapath
// operations, controller command and datapath status bundles.
// ----------------------------------------------------------------------------
package pllm_pkg;

   // request modes
   localparam logic [1:0] MODE_ADD  = 2'd0;
   localparam logic [1:0] MODE_FREE = 2'd1;
   localparam logic [1:0] MODE_POP  = 2'd2;
   localparam logic [1:0] MODE_READ = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_DAMAGED = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ALLOC_FREE,
      OP_ALLOC_TAKE,
      OP_ALLOC_BUMP,
      OP_INIT_REC,
      OP_READ_CUR,
      OP_STEP,
      OP_HOP,
      OP_LINK_TAIL,
      OP_REV_WR,
      OP_PHASE2,
      OP_REL_ADV,
      OP_POP_REL,
      OP_CLR_PREV,
      OP_CAP_READ,
      OP_EMIT
   } dp_op_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type  op;
      logic       fin;
      logic [1:0] code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       cur_zero;
      logic       rd_zero;
      logic       steps_max;
      logic       free_zero;
      logic       pool_full;
      logic       out_free;
   } stat_type;

endpackage

// File: rtl/core/pllm_ram.sv
// ----------------------------------------------------------------------------
// pllm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pllm_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// File: rtl/core/pllm_datapath.sv
// ----------------------------------------------------------------------------
// pllm_datapath
// Record pool storage, walk registers, free list and bump pointer, result
// staging and the response register.
// ----------------------------------------------------------------------------
module pllm_datapath #(
   parameter int RECORDS      = 1024,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  pllm_pkg::cmd_type  cmd,
   output pllm_pkg::stat_type stat,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_list_index,
   input  logic [15:0]        req_payload_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_record_index,
   output logic [15:0]        rsp_payload_out,
   output logic [9:0]         rsp_link_out,
   output logic               rsp_list_now_empty,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(RECORDS);

   logic [1:0]              mode_ff;
   logic [AW-1:0]           cur_ff, cur_in;
   logic [AW-1:0]           prev_ff, prev_in;
   logic [AW:0]             steps_ff, steps_in;
   logic [AW-1:0]           r_ff, r_in;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [AW-1:0]           free_head_ff, free_head_in;
   logic [AW:0]             bump_ff, bump_in;

   logic [AW-1:0]           res_rec_ff, res_rec_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;
   logic [AW-1:0]           res_link_ff, res_link_in;
   logic                    res_empty_ff, res_empty_in;
   logic [1:0]              res_status_ff, res_status_in;

   logic                    rsp_valid_ff;
   logic [9:0]              rsp_rec_ff;
   logic [15:0]             rsp_pay_ff;
   logic [9:0]              rsp_link_ff;
   logic                    rsp_empty_ff;
   logic [1:0]              rsp_status_ff;

   logic                    link_we, link_re;
   logic [AW-1:0]           link_waddr, link_raddr, link_wdata, link_rd;
   logic                    pay_we;
   logic [PAYLOAD_BITS-1:0] pay_rd;

   logic                    idx_ok;
   logic                    rel_bump;

   // record link and payload stores
   pllm_ram #(.WIDTH(AW), .DEPTH(RECORDS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rd)
   );

   pllm_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(RECORDS)) u_pay_ram (
      .clock (clock),
      .we    (pay_we),
      .waddr (r_ff),
      .wdata (pay_ff),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (pay_rd)
   );

   // index range check and release decision
   assign idx_ok   = 17'(req_list_index) < 17'(RECORDS);
   assign rel_bump = (bump_ff != '0) && ({1'b0, cur_ff} == bump_ff - 1'b1);

   // status to controller
   assign stat.mode      = mode_ff;
   assign stat.cur_zero  = (cur_ff == '0);
   assign stat.rd_zero   = (link_rd == '0);
   assign stat.steps_max = (steps_ff >= (AW+1)'(RECORDS));
   assign stat.free_zero = (free_head_ff == '0);
   assign stat.pool_full = (bump_ff >= (AW+1)'(RECORDS));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   // memory port control
   always_comb begin
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = '0;
      link_re    = 1'b0;
      link_raddr = cur_ff;
      pay_we     = 1'b0;
      case (cmd.op)
         pllm_pkg::OP_ALLOC_FREE: begin
            link_re    = 1'b1;
            link_raddr = free_head_ff;
         end
         pllm_pkg::OP_READ_CUR: begin
            link_re = 1'b1;
         end
         pllm_pkg::OP_INIT_REC: begin
            link_we    = 1'b1;
            link_waddr = r_ff;
            pay_we     = 1'b1;
         end
         pllm_pkg::OP_LINK_TAIL: begin
            link_we    = 1'b1;
            link_wdata = r_ff;
         end
         pllm_pkg::OP_REV_WR: begin
            link_we    = 1'b1;
            link_wdata = prev_ff;
         end
         pllm_pkg::OP_REL_ADV, pllm_pkg::OP_POP_REL: begin
            link_we    = 1'b1;
            link_wdata = rel_bump ? '0 : free_head_ff;
         end
         pllm_pkg::OP_CLR_PREV: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
         end
         default: begin
         end
      endcase
   end

   // walk, pool and result staging next state
   always_comb begin
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      r_in          = r_ff;
      free_head_in  = free_head_ff;
      bump_in       = bump_ff;
      res_rec_in    = res_rec_ff;
      res_pay_in    = res_pay_ff;
      res_link_in   = res_link_ff;
      res_empty_in  = res_empty_ff;
      res_status_in = cmd.fin ? cmd.code : res_status_ff;
      case (cmd.op)
         pllm_pkg::OP_LOAD: begin
            cur_in       = idx_ok ? AW'(req_list_index) : '0;
            prev_in      = '0;
            steps_in     = '0;
            res_rec_in   = '0;
            res_pay_in   = '0;
            res_link_in  = '0;
            res_empty_in = 1'b0;
         end
         pllm_pkg::OP_ALLOC_FREE: begin
            r_in = free_head_ff;
         end
         pllm_pkg::OP_ALLOC_TAKE: begin
            free_head_in = link_rd;
         end
         pllm_pkg::OP_ALLOC_BUMP: begin
            r_in    = bump_ff[AW-1:0];
            bump_in = bump_ff + 1'b1;
         end
         pllm_pkg::OP_INIT_REC: begin
            res_rec_in = r_ff;
         end
         pllm_pkg::OP_STEP: begin
            prev_in  = cur_ff;
            cur_in   = link_rd;
            steps_in = steps_ff + 1'b1;
         end
         pllm_pkg::OP_HOP: begin
            prev_in = cur_ff;
            cur_in  = link_rd;
         end
         pllm_pkg::OP_REV_WR: begin
            prev_in  = cur_ff;
            cur_in   = link_rd;
            steps_in = steps_ff + 1'b1;
         end
         pllm_pkg::OP_PHASE2: begin
            cur_in   = prev_ff;
            prev_in  = '0;
            steps_in = '0;
         end
         pllm_pkg::OP_REL_ADV: begin
            if (rel_bump) begin
               bump_in = bump_ff - 1'b1;
            end else begin
               free_head_in = cur_ff;
            end
            cur_in   = link_rd;
            steps_in = steps_ff + 1'b1;
         end
         pllm_pkg::OP_POP_REL: begin
            if (rel_bump) begin
               bump_in = bump_ff - 1'b1;
            end else begin
               free_head_in = cur_ff;
            end
            res_rec_in   = cur_ff;
            res_pay_in   = pay_rd;
            res_empty_in = (prev_ff == '0);
         end
         pllm_pkg::OP_CAP_READ: begin
            res_rec_in  = cur_ff;
            res_pay_in  = pay_rd;
            res_link_in = link_rd;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         bump_ff      <= (AW+1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         bump_ff      <= bump_in;
         if (cmd.op == pllm_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == pllm_pkg::OP_LOAD) begin
         mode_ff <= req_mode;
         pay_ff  <= PAYLOAD_BITS'(req_payload_in);
      end
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      r_ff          <= r_in;
      res_rec_ff    <= res_rec_in;
      res_pay_ff    <= res_pay_in;
      res_link_ff   <= res_link_in;
      res_empty_ff  <= res_empty_in;
      res_status_ff <= res_status_in;
      if (cmd.op == pllm_pkg::OP_EMIT) begin
         rsp_rec_ff    <= 10'(res_rec_ff);
         rsp_pay_ff    <= 16'(res_pay_ff);
         rsp_link_ff   <= 10'(res_link_ff);
         rsp_empty_ff  <= res_empty_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_index   = rsp_rec_ff;
   assign rsp_payload_out    = rsp_pay_ff;
   assign rsp_link_out       = rsp_link_ff;
   assign rsp_list_now_empty = rsp_empty_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// File: rtl/core/pllm_ctrl.sv
// ----------------------------------------------------------------------------
// pllm_ctrl
// Sequencer for add, free, pop and read transactions; drives datapath
// operations one link access at a time.
// ----------------------------------------------------------------------------
module pllm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pllm_pkg::stat_type stat,
   output pllm_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_A_TAKE, S_A_INIT, S_A_RD, S_A_CHK,
      S_F_REV, S_F_REVW, S_F_REL, S_F_RELW,
      S_P_FIRST, S_P_RD, S_P_CHK, S_P_CLR, S_R_CAP, S_FIN
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = pllm_pkg::OP_NONE;
      cmd.fin  = 1'b0;
      cmd.code = pllm_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = pllm_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.mode == pllm_pkg::MODE_ADD) begin
               if (!stat.free_zero) begin
                  cmd.op   = pllm_pkg::OP_ALLOC_FREE;
                  state_in = S_A_TAKE;
               end else if (stat.pool_full) begin
                  cmd.fin  = 1'b1;
                  cmd.code = pllm_pkg::ST_FULL;
                  state_in = S_FIN;
               end else begin
                  cmd.op   = pllm_pkg::OP_ALLOC_BUMP;
                  state_in = S_A_INIT;
               end
            end else if (stat.cur_zero) begin
               cmd.fin  = 1'b1;
               cmd.code = pllm_pkg::ST_EMPTY;
               state_in = S_FIN;
            end else if (stat.mode == pllm_pkg::MODE_FREE) begin
               state_in = S_F_REV;
            end else if (stat.mode == pllm_pkg::MODE_POP) begin
               cmd.op   = pllm_pkg::OP_READ_CUR;
               state_in = S_P_FIRST;
            end else begin
               cmd.op   = pllm_pkg::OP_READ_CUR;
               state_in = S_R_CAP;
            end
         end
         // add: allocate, init, then walk to the tail
         S_A_TAKE: begin
            cmd.op   = pllm_pkg::OP_ALLOC_TAKE;
            state_in = S_A_INIT;
         end
         S_A_INIT: begin
            cmd.op = pllm_pkg::OP_INIT_REC;
            if (stat.cur_zero) begin
               cmd.fin  = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            cmd.op   = pllm_pkg::OP_READ_CUR;
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (stat.rd_zero || stat.steps_max) begin
               cmd.op   = pllm_pkg::OP_LINK_TAIL;
               cmd.fin  = 1'b1;
               cmd.code = stat.rd_zero ? pllm_pkg::ST_OK : pllm_pkg::ST_DAMAGED;
               state_in = S_FIN;
            end else begin
               cmd.op   = pllm_pkg::OP_STEP;
               state_in = S_A_RD;
            end
         end
         // free: reverse the chain, then release tail first
         S_F_REV: begin
            if (stat.cur_zero) begin
               cmd.op   = pllm_pkg::OP_PHASE2;
               state_in = S_F_REL;
            end else if (stat.steps_max) begin
               cmd.fin  = 1'b1;
               cmd.code = pllm_pkg::ST_DAMAGED;
               state_in = S_FIN;
            end else begin
               cmd.op   = pllm_pkg::OP_READ_CUR;
               state_in = S_F_REVW;
            end
         end
         S_F_REVW: begin
            cmd.op   = pllm_pkg::OP_REV_WR;
            state_in = S_F_REV;
         end
         S_F_REL: begin
            if (stat.cur_zero || stat.steps_max) begin
               cmd.fin  = 1'b1;
               cmd.code = stat.cur_zero ? pllm_pkg::ST_OK : pllm_pkg::ST_DAMAGED;
               state_in = S_FIN;
            end else begin
               cmd.op   = pllm_pkg::OP_READ_CUR;
               state_in = S_F_RELW;
            end
         end
         S_F_RELW: begin
            cmd.op   = pllm_pkg::OP_REL_ADV;
            state_in = S_F_REL;
         end
         // pop: find the tail and its predecessor
         S_P_FIRST: begin
            if (stat.rd_zero) begin
               cmd.op   = pllm_pkg::OP_POP_REL;
               cmd.fin  = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd.op   = pllm_pkg::OP_HOP;
               state_in = S_P_RD;
            end
         end
         S_P_RD: begin
            cmd.op   = pllm_pkg::OP_READ_CUR;
            state_in = S_P_CHK;
         end
         S_P_CHK: begin
            if (stat.rd_zero) begin
               cmd.op   = pllm_pkg::OP_POP_REL;
               state_in = S_P_CLR;
            end else if (stat.steps_max) begin
               cmd.fin  = 1'b1;
               cmd.code = pllm_pkg::ST_DAMAGED;
               state_in = S_FIN;
            end else begin
               cmd.op   = pllm_pkg::OP_STEP;
               state_in = S_P_RD;
            end
         end
         S_P_CLR: begin
            cmd.op   = pllm_pkg::OP_CLR_PREV;
            cmd.fin  = 1'b1;
            state_in = S_FIN;
         end
         S_R_CAP: begin
            cmd.op   = pllm_pkg::OP_CAP_READ;
            cmd.fin  = 1'b1;
            state_in = S_FIN;
         end
         // hand the result to the response register
         S_FIN: begin
            if (stat.out_free) begin
               cmd.op   = pllm_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/pooled_linked_list_manager.sv
// ----------------------------------------------------------------------------
// pooled_linked_list_manager
// Record pool holding singly linked lists with free list and bump allocation.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and yields exactly one response. Each
// link visited takes a read on the single read port of the link RAM, so add,
// pop and free take longer on longer lists, and free visits each link twice;
// any wait on rsp_stall comes on top. A new request is taken as soon as the
// previous result sits in the response register, even if that result is
// still stalled. Record 0 means none.
module pooled_linked_list_manager #(
   parameter int RECORDS      = 1024,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [9:0]  req_list_index,
   input  logic [15:0] req_payload_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_record_index,
   output logic [15:0] rsp_payload_out,
   output logic [9:0]  rsp_link_out,
   output logic        rsp_list_now_empty,
   output logic [1:0]  rsp_status
);

   pllm_pkg::cmd_type  cmd;
   pllm_pkg::stat_type stat;

   // sequencer
   pllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and registers
   pllm_datapath #(
      .RECORDS      (RECORDS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_mode),
      .req_list_index     (req_list_index),
      .req_payload_in     (req_payload_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_index   (rsp_record_index),
      .rsp_payload_out    (rsp_payload_out),
      .rsp_link_out       (rsp_link_out),
      .rsp_list_now_empty (rsp_list_now_empty),
      .rsp_status         (rsp_status)
   );

endmodule

// File: rtl/core/pllm_checker.sv
// ----------------------------------------------------------------------------
// pllm_checker
// Port level checks of the pooled linked list manager, bound to the top.
// ----------------------------------------------------------------------------
module pllm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_record_index,
   input logic [15:0] rsp_payload_out,
   input logic        rsp_list_now_empty,
   input logic [1:0]  rsp_status
);

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record_index))
      else $error("stalled response changed");

   // one request in flight: the block stalls right after taking one
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // empty or full answers carry no record
   a_no_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pllm_pkg::ST_EMPTY || rsp_status == pllm_pkg::ST_FULL)
      |-> rsp_record_index == '0 && rsp_payload_out == '0)
      else $error("record reported with empty or full status");

   // emptied list flag only on a good pop
   a_empty_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_now_empty |-> rsp_status == pllm_pkg::ST_OK)
      else $error("list emptied flag with error status");

endmodule

bind pooled_linked_list_manager pllm_checker u_pllm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_record_index   (rsp_record_index),
   .rsp_payload_out    (rsp_payload_out),
   .rsp_list_now_empty (rsp_list_now_empty),
   .rsp_status         (rsp_status)
);
